// File: design/pwvm_pkg.sv
`default_nettype none
package pwvm_pkg;
	localparam int VOICES_DEF = 64;
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int PHASE_BITS_DEF = 24;
	localparam logic [8:0] TABLE_LENGTH_RST = 9'd20;
	localparam logic [7:0] SAMPLE_MAX = 8'd255;

	typedef enum logic [1:0] {
		FUNC_NOTE_ON  = 2'd0,
		FUNC_NOTE_OFF = 2'd1,
		FUNC_TICK     = 2'd2,
		FUNC_TWRITE   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_ON_WRITE,
		ST_OFF_READ,
		ST_OFF_WAIT,
		ST_OFF_WRITE,
		ST_TICK_READ,
		ST_TICK_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       clr_slot;
		logic       inc_slot;
		logic       rd_slot;
		logic       rd_last;
		logic       wr_new;
		logic       wr_move;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       tick_rd;
		logic       tick_clr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		func_t      func;
		logic       slot_end;
		logic       hit;
		logic       full;
		logic       step_zero;
		logic       cnt_zero;
		logic       drained;
	} sts_t;

	// reset content of the wavetable
	function automatic logic [7:0] wave_init(input logic [11:0] i);
		case (i)
			12'd1:   wave_init = 8'd64;
			12'd2:   wave_init = 8'd128;
			12'd3:   wave_init = 8'd192;
			12'd4:   wave_init = 8'd255;
			default: wave_init = 8'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// File: design/pwvm_ctrl.sv
`default_nettype none
module pwvm_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	input  wire pwvm_pkg::sts_t sts,
	output pwvm_pkg::cmd_t    cmd
);
	pwvm_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pwvm_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			pwvm_pkg::ST_IDLE: begin
				// input held off until the wavetable load after reset is done
				in_stall = !sts.drained;
				if (in_valid && sts.drained) begin
					cmd.load = 1'b1;
					cmd.clr_slot = 1'b1;
					state_nx = pwvm_pkg::ST_SEARCH;
				end
			end
			pwvm_pkg::ST_SEARCH: begin
				case (sts.func)
					pwvm_pkg::FUNC_NOTE_ON, pwvm_pkg::FUNC_NOTE_OFF: begin
						if (sts.slot_end) state_nx = pwvm_pkg::ST_SEARCH_WAIT;
						else begin
							cmd.rd_slot = 1'b1;
							state_nx = pwvm_pkg::ST_SEARCH_WAIT;
						end
					end
					pwvm_pkg::FUNC_TICK: begin
						cmd.tick_clr = 1'b1;
						state_nx = pwvm_pkg::ST_TICK_READ;
					end
					default: state_nx = pwvm_pkg::ST_IDLE;
				endcase
			end
			pwvm_pkg::ST_SEARCH_WAIT: begin
				if (sts.hit) begin
					if (sts.func == pwvm_pkg::FUNC_NOTE_OFF) begin
						cmd.rd_last = 1'b1;
						state_nx = pwvm_pkg::ST_OFF_WAIT;
					end else state_nx = pwvm_pkg::ST_IDLE;
				end else if (sts.slot_end) begin
					if (sts.func == pwvm_pkg::FUNC_NOTE_ON &&
					    !sts.full && !sts.step_zero)
						state_nx = pwvm_pkg::ST_ON_WRITE;
					else state_nx = pwvm_pkg::ST_IDLE;
				end else begin
					cmd.inc_slot = 1'b1;
					state_nx = pwvm_pkg::ST_SEARCH;
				end
			end
			pwvm_pkg::ST_ON_WRITE: begin
				cmd.wr_new = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_nx = pwvm_pkg::ST_IDLE;
			end
			pwvm_pkg::ST_OFF_WAIT: state_nx = pwvm_pkg::ST_OFF_WRITE;
			pwvm_pkg::ST_OFF_WRITE: begin
				cmd.wr_move = 1'b1;
				cmd.cnt_dec = 1'b1;
				state_nx = pwvm_pkg::ST_IDLE;
			end
			pwvm_pkg::ST_TICK_READ: begin
				if (sts.slot_end) state_nx = pwvm_pkg::ST_TICK_DRAIN;
				else begin
					cmd.tick_rd = 1'b1;
					cmd.inc_slot = 1'b1;
				end
			end
			pwvm_pkg::ST_TICK_DRAIN: begin
				if (sts.drained) begin
					cmd.out_load = 1'b1;
					state_nx = pwvm_pkg::ST_OUT;
				end
			end
			pwvm_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_nx = pwvm_pkg::ST_IDLE;
			end
			default: state_nx = pwvm_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: design/pwvm_datapath.sv
`default_nettype none
module pwvm_datapath #(
	parameter int VOICES = pwvm_pkg::VOICES_DEF,
	parameter int TABLE_DEPTH = pwvm_pkg::TABLE_DEPTH_DEF,
	parameter int PHASE_BITS = pwvm_pkg::PHASE_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [1:0]        func,
	input  wire  [10:0]       voice_id,
	input  wire  [24:0]       phase_inc,
	input  wire  [7:0]        table_index,
	input  wire  [7:0]        table_value,
	input  wire  [8:0]        table_length,
	input  wire pwvm_pkg::cmd_t cmd,
	output pwvm_pkg::sts_t    sts,
	output logic [7:0]        sample
);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam logic [PHASE_BITS:0] ONE_TURN = {1'b1, {PHASE_BITS{1'b0}}};
	localparam int RW = (25 > PHASE_BITS + 1) ? 25 : PHASE_BITS + 1;

	// voice memories and wavetable
	logic [10:0]           ids_mem   [VOICES];
	logic [PHASE_BITS-1:0] phase_mem [VOICES];
	logic [PHASE_BITS:0]   step_mem  [VOICES];
	logic [7:0]            wave_mem  [TABLE_DEPTH];

	logic [1:0]            func_q;
	logic [10:0]           id_q;
	logic [PHASE_BITS:0]   step_q;
	logic [CW-1:0]         cnt_q, slot_q;
	logic [10:0]           rd_id_q;
	logic                  cmp_v_q;
	logic [VW-1:0]         hit_slot_q;
	logic                  hit_q;
	logic [10:0]           mv_id_q;
	logic [PHASE_BITS-1:0] mv_ph_q;
	logic [PHASE_BITS:0]   mv_st_q;
	logic [LW-1:0]         len_q;
	logic [11:0]           sweep_q;
	logic                  init_q;

	// tick pipeline
	logic                  v_s1, v_s2, v_s3;
	logic [VW-1:0]         a_s1;
	logic [PHASE_BITS-1:0] ph_s1;
	logic [PHASE_BITS:0]   st_s1;
	logic [PHASE_BITS-1:0] ph_s2;
	logic [LW+PHASE_BITS-1:0] prod_s3;
	logic                  v_s4, v_s5;
	logic [TW-1:0]         idx_s4;
	logic [7:0]            val_s5;
	logic [8:0]            acc_q;

	logic [RW-1:0]         inc_w;
	logic [PHASE_BITS:0]   inc_sat;
	logic [VW-1:0]         slot_a, last_a, cnt_a;
	logic [PHASE_BITS:0]   ph_sum;
	logic [LW+PHASE_BITS-1:0] idx_full;

	assign inc_w   = RW'(phase_inc);
	assign inc_sat = (inc_w > RW'(ONE_TURN)) ? ONE_TURN : inc_w[PHASE_BITS:0];
	assign slot_a  = slot_q[VW-1:0];
	assign cnt_a   = cnt_q[VW-1:0];
	assign last_a  = VW'(cnt_q - CW'(1));
	assign ph_sum  = {1'b0, ph_s1} + st_s1;
	assign idx_full = prod_s3 >> PHASE_BITS;

	// item capture, count and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			slot_q <= '0;
			cmp_v_q <= 1'b0;
			hit_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0;
			init_q <= 1'b1;
			sweep_q <= '0;
		end else begin
			if (cmd.load) begin
				func_q <= func;
				id_q <= voice_id;
				step_q <= inc_sat;
				len_q <= (32'(table_length) > TABLE_DEPTH) ? LW'(TABLE_DEPTH)
				         : LW'(table_length);
			end
			if (cmd.clr_slot || cmd.tick_clr) slot_q <= '0;
			else if (cmd.inc_slot) slot_q <= slot_q + CW'(1);
			if (cmd.clr_slot) hit_q <= 1'b0;
			cmp_v_q <= cmd.rd_slot;
			if (cmp_v_q && rd_id_q == id_q) begin
				hit_q <= 1'b1;
				hit_slot_q <= slot_a;
			end
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			v_s1 <= cmd.tick_rd;
			a_s1 <= slot_a;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (init_q) begin
				sweep_q <= sweep_q + 12'd1;
				if (sweep_q == 12'(TABLE_DEPTH - 1)) init_q <= 1'b0;
			end
		end
	end

	// voice memory access
	always_ff @(posedge clk) begin
		if (cmd.rd_slot) rd_id_q <= ids_mem[slot_a];
		if (cmd.rd_last) begin
			mv_id_q <= ids_mem[last_a];
			mv_ph_q <= phase_mem[last_a];
			mv_st_q <= step_mem[last_a];
		end
		if (cmd.tick_rd) begin
			ph_s1 <= phase_mem[slot_a];
			st_s1 <= step_mem[slot_a];
		end
		if (cmd.wr_new) begin
			ids_mem[cnt_a] <= id_q;
			phase_mem[cnt_a] <= '0;
			step_mem[cnt_a] <= step_q;
		end else if (cmd.wr_move) begin
			ids_mem[hit_slot_q] <= mv_id_q;
			phase_mem[hit_slot_q] <= mv_ph_q;
			step_mem[hit_slot_q] <= mv_st_q;
		end else if (v_s1) begin
			phase_mem[a_s1] <= ph_sum[PHASE_BITS-1:0];
		end
	end

	// phase to index, table read, accumulate
	always_ff @(posedge clk) begin
		ph_s2 <= ph_sum[PHASE_BITS-1:0];
		prod_s3 <= (LW+PHASE_BITS)'(len_q) * (LW+PHASE_BITS)'(ph_s2);
		idx_s4 <= (idx_full >= (LW+PHASE_BITS)'(TABLE_DEPTH)) ? '0 : TW'(idx_full);
		val_s5 <= wave_mem[idx_s4];
		if (init_q) wave_mem[TW'(sweep_q)] <= pwvm_pkg::wave_init(sweep_q);
		else if (cmd.load && func == pwvm_pkg::FUNC_TWRITE &&
		         32'(table_index) < TABLE_DEPTH)
			wave_mem[TW'(table_index)] <= table_value;
		if (cmd.tick_clr) acc_q <= '0;
		else if (v_s5) acc_q <= (acc_q + 9'(val_s5) > 9'(pwvm_pkg::SAMPLE_MAX))
		                       ? 9'(pwvm_pkg::SAMPLE_MAX) : acc_q + 9'(val_s5);
		if (cmd.out_load) sample <= acc_q[7:0];
	end

	// status to controller
	always_comb begin
		sts.func = pwvm_pkg::func_t'(func_q);
		sts.slot_end = (slot_q >= cnt_q);
		sts.hit = hit_q || (cmp_v_q && rd_id_q == id_q);
		sts.full = (cnt_q >= CW'(VOICES));
		sts.step_zero = (step_q == '0);
		sts.cnt_zero = (cnt_q == '0);
		sts.drained = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5) && !init_q;
	end
endmodule
`default_nettype wire

// File: design/polyphonic_wavetable_voice_mixer.sv
`default_nettype none
// Wavetable voice mixer: note-on and note-off items take a linear search of the voice table,
// one active voice after another; a sample tick streams every active voice through a
// five-stage phase, index and table-read pipeline at one voice a cycle. After reset the
// wavetable is swept with its reset content and the input is stalled until that sweep is
// done. The sample is held until the output beat is taken, and no input is taken meanwhile.
module polyphonic_wavetable_voice_mixer #(
	parameter int VOICES = pwvm_pkg::VOICES_DEF,
	parameter int TABLE_DEPTH = pwvm_pkg::TABLE_DEPTH_DEF,
	parameter int PHASE_BITS = pwvm_pkg::PHASE_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  func,
	input  wire  [10:0] voice_id,
	input  wire  [24:0] phase_inc,
	input  wire  [7:0]  table_index,
	input  wire  [7:0]  table_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  sample,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	pwvm_pkg::cmd_t cmd;
	pwvm_pkg::sts_t sts;
	logic [8:0] table_length_q;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {23'd0, table_length_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) table_length_q <= pwvm_pkg::TABLE_LENGTH_RST;
		else if (psel && penable && pwrite && paddr == 2'd0)
			table_length_q <= pwdata[8:0];
	end

	pwvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	pwvm_datapath #(.VOICES(VOICES), .TABLE_DEPTH(TABLE_DEPTH), .PHASE_BITS(PHASE_BITS))
	u_dp (
		.clk(clk), .arst_n(arst_n), .func(func), .voice_id(voice_id),
		.phase_inc(phase_inc), .table_index(table_index), .table_value(table_value),
		.table_length(table_length_q), .cmd(cmd), .sts(sts), .sample(sample)
	);
endmodule
`default_nettype wire

// File: design/pwvm_checker.sv
`default_nettype none
module pwvm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [1:0] func,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] sample
);
	// a waiting sample holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample))
		else $error("sample changed under stall");
	// no input taken while a sample is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken with sample pending");
	// an accepted item blocks the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("back to back accept");
	// a non-tick item yields no sample right after it is accepted
	a_notick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func != pwvm_pkg::FUNC_TICK |=> !out_valid)
		else $error("sample without tick");
endmodule

bind polyphonic_wavetable_voice_mixer pwvm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.func(func), .out_valid(out_valid), .out_stall(out_stall), .sample(sample)
);
`default_nettype wire

// File: dv/tb_polyphonic_wavetable_voice_mixer.sv
`timescale 1ns / 1ps
module tb_polyphonic_wavetable_voice_mixer;
	localparam int NVOICE = 64;
	localparam int DEPTH = 256;
	localparam logic [1:0] REG_TABLE_LENGTH = 2'd0;
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		pwvm_pkg::func_t func;
		logic [10:0] voice_id;
		logic [24:0] phase_inc;
		logic [7:0]  table_index;
		logic [7:0]  table_value;
	} note_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic [10:0] voice_id = '0;
	logic [24:0] phase_inc = '0;
	logic [7:0] table_index = '0;
	logic [7:0] table_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] sample;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	polyphonic_wavetable_voice_mixer i_dut (.*);

	// mirror of the mixer state
	logic [8:0]  mix_len;
	int          mix_count;
	logic [10:0] mix_id[NVOICE];
	logic [23:0] mix_phase[NVOICE];
	logic [24:0] mix_step[NVOICE];
	logic [7:0]  mix_wave[DEPTH];

	note_cmd_t   pending_cmds[$];
	logic [7:0]  expected_samples[$];
	int errors = 0;
	int samples_seen = 0;
	int idle_cycles = 0;
	int hold_req = 0;
	int sent_n = 0;
	int taken_n = 0;
	bit stim_done = 0;

	function automatic int find_voice(input logic [10:0] id);
		for (int k = 0; k < mix_count; k++)
			if (mix_id[k] == id) return k;
		return -1;
	endfunction

	// apply one accepted command to the mirror
	task automatic mix_apply(input note_cmd_t c);
		int k;
		int sum;
		logic [24:0] st;
		logic [32:0] prod;
		logic [8:0] idx;
		logic [8:0] len;
		case (c.func)
			pwvm_pkg::FUNC_NOTE_ON: begin
				st = (c.phase_inc > 25'h1000000) ? 25'h1000000 : c.phase_inc;
				if (st != 0 && mix_count < NVOICE && find_voice(c.voice_id) < 0) begin
					mix_id[mix_count] = c.voice_id;
					mix_phase[mix_count] = '0;
					mix_step[mix_count] = st;
					mix_count++;
				end
			end
			pwvm_pkg::FUNC_NOTE_OFF: begin
				k = find_voice(c.voice_id);
				if (k >= 0) begin
					mix_id[k] = mix_id[mix_count-1];
					mix_phase[k] = mix_phase[mix_count-1];
					mix_step[k] = mix_step[mix_count-1];
					mix_count--;
				end
			end
			pwvm_pkg::FUNC_TICK: begin
				sum = 0;
				len = (mix_len > DEPTH) ? 9'(DEPTH) : mix_len;
				for (k = 0; k < mix_count; k++) begin
					mix_phase[k] = 24'(mix_phase[k] + mix_step[k]);
					prod = len * mix_phase[k];
					idx = prod[32:24];
					if (idx >= DEPTH) idx = 0;
					sum += mix_wave[idx];
				end
				expected_samples.push_back(sum > 255 ? 8'd255 : 8'(sum));
			end
			default: mix_wave[c.table_index] = c.table_value;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver: a beat stays up until it is taken, then the drawn gap follows
	int gap = 0;
	always @(negedge clk) begin
		note_cmd_t c;
		if (in_valid && sent_n != taken_n) begin
			// beat still waiting, payload held
		end else if (gap > 0) begin
			gap <= gap - 1;
			in_valid <= 1'b0;
		end else if (pending_cmds.size() > 0) begin
			c = pending_cmds.pop_front();
			func <= c.func;
			voice_id <= c.voice_id;
			phase_inc <= c.phase_inc;
			table_index <= c.table_index;
			table_value <= c.table_value;
			in_valid <= 1'b1;
			sent_n <= sent_n + 1;
			gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// predictor fed by accepted input beats
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			mix_apply('{pwvm_pkg::func_t'(func), voice_id, phase_inc, table_index,
				table_value});
			taken_n++;
		end
	end

	// receiver stall: a drawn wait after every beat, plus long holds on request
	int rwait = 0;
	int long_left = 0;
	int hold_done = 0;
	int rx_drawn = 0;
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			long_left = LONG_HOLD;
		end
		if (samples_seen != rx_drawn) begin
			rx_drawn = samples_seen;
			rwait = $urandom_range(0, 6);
		end
		if (long_left > 0) begin
			long_left--;
			out_stall <= 1'b1;
		end else if (rwait > 0) begin
			rwait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				$error("unexpected sample beat: actual %0d", sample);
				errors++;
			end else begin
				logic [7:0] e;
				e = expected_samples.pop_front();
				if (sample !== e) begin
					$error("sample mismatch: expected %0d actual %0d", e, sample);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat in %0d cycles", IDLE_LIMIT);
			$display("tb_polyphonic_wavetable_voice_mixer: FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_len(input logic [8:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_TABLE_LENGTH; pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mix_len = v;
	endtask

	function automatic note_cmd_t mk(input pwvm_pkg::func_t f, input logic [10:0] id,
			input logic [24:0] inc, input logic [7:0] ti, input logic [7:0] tv);
		return '{f, id, inc, ti, tv};
	endfunction

	function automatic logic [24:0] rand_inc();
		case ($urandom_range(0, 5))
			0: return 25'h1000000 + 25'($urandom_range(0, 25'hFFFFFF));
			1: return 25'h1000000;
			2: return 25'($urandom_range(1, 16));
			default: return 25'($urandom_range(1, 25'h3FFFFF));
		endcase
	endfunction

	// random phase: well-formed voice traffic mixed with ticks and table writes
	task automatic random_burst(input int n);
		logic [10:0] ids[$];
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				if (ids.size() > 0 && $urandom_range(0, 7) == 0)
					pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, ids[0], rand_inc(),
						'0, '0));
				else begin
					ids.push_back(11'($urandom_range(0, 2047)));
					pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, ids[$], rand_inc(),
						8'($urandom), 8'($urandom)));
				end
			end else if (r < 45) begin
				if (ids.size() > 0 && $urandom_range(0, 4) != 0) begin
					int j = $urandom_range(0, ids.size() - 1);
					pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, ids[j],
						25'($urandom), '0, '0));
					ids.delete(j);
				end else
					pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'($urandom),
						'0, '0, '0));
			end else if (r < 85) begin
				pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, 11'($urandom),
					25'($urandom), '0, '0));
			end else if (r < 88) begin
				pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'($urandom), 25'd0,
					'0, '0));
			end else begin
				pending_cmds.push_back(mk(pwvm_pkg::FUNC_TWRITE, 11'($urandom),
					25'($urandom), 8'($urandom), 8'($urandom)));
			end
		end
	endtask

	initial begin
		logic [8:0] lens[6];
		lens = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd20, 9'd137};
		mix_len = pwvm_pkg::TABLE_LENGTH_RST;
		mix_count = 0;
		for (int k = 0; k < DEPTH; k++) mix_wave[k] = 8'(pwvm_pkg::wave_init(12'(k)));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes and special cases at the reset length
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd0, 25'h100000, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd0, 25'h200000, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd2047, 25'h1FFFFFF,
			8'hFF, 8'hFF));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd5, 25'd0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd7, 25'h800000, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'd9, 25'h1, '0, '0));
		repeat (4) pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'd1234, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'd0, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TWRITE, '0, '0, 8'd0, 8'd255));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TWRITE, '0, '0, 8'd255, 8'd170));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TWRITE, '0, '0, 8'd10, 8'd85));
		repeat (3) pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'd9, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'd2047, '0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		wait_drained();

		// fill the table past its capacity
		for (int k = 0; k < NVOICE + 2; k++)
			pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_ON, 11'(k * 31 + 3), rand_inc(),
				'0, '0));
		repeat (3) pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		for (int k = 0; k < NVOICE + 2; k++)
			pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, 11'(k * 31 + 3),
				'0, '0, '0));
		pending_cmds.push_back(mk(pwvm_pkg::FUNC_TICK, '0, '0, '0, '0));
		wait_drained();

		// random phases over several lookup lengths, extremes included
		for (int i = 0; i < 6; i++) begin
			write_len(lens[i]);
			if (i == 2) hold_req++;
			random_burst(130);
			wait_drained();
			// clear leftover voices
			while (mix_count > 0) begin
				pending_cmds.push_back(mk(pwvm_pkg::FUNC_NOTE_OFF, mix_id[mix_count-1],
					'0, '0, '0));
				wait_drained();
			end
		end
		stim_done = 1;
		wait_drained();

		$display("covered note on/off incl. duplicates, full table and zero steps, ticks, writes");
		$display("table lengths 0..511 tried, %0d samples checked", samples_seen);
		if (errors == 0 && expected_samples.size() == 0)
			$display("tb_polyphonic_wavetable_voice_mixer: PASS");
		else
			$display("tb_polyphonic_wavetable_voice_mixer: FAIL");
		$finish;
	end
endmodule
